// ===== sv/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII digit emitter.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int NUM_BITS       = 32;            // width of the binary number
  localparam int COUNT_W        = 5;             // width of the requested digit count
  localparam int NUM_POS        = 10;            // decimal positions a 32-bit number can fill
  localparam int BIT_CNT_W      = $clog2(NUM_BITS);
  localparam int CHAR_W         = 6;             // width of one ASCII digit code
  localparam int DEF_MAX_DIGITS = 16;

  localparam logic [3:0]        DABBLE_LIMIT = 4'd5;
  localparam logic [3:0]        DABBLE_ADJ   = 4'd3;
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } b2da_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture number and count, clear the BCD register
    logic shift;    // one double-dabble step
    logic advance;  // step down to the next lower digit position
  } b2da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;  // offered item asks for no digits
    logic conv_last;   // this shift is the final one of the conversion
    logic pos_zero;    // current digit is the units digit
  } b2da_stat_t;

endpackage

// ===== sv/b2da_ctrl.sv =====
// Controller for the digit emitter: idle, bit-serial conversion, digit output.
// Depends on b2da_pkg; drives commands into b2da_dp and owns both handshakes.
`timescale 1ns / 1ps

module b2da_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  b2da_pkg::b2da_stat_t stat,
  output b2da_pkg::b2da_cmd_t  cmd
);
  import b2da_pkg::*;

  b2da_state_t state;
  b2da_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.count_zero) begin
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        if (stat.conv_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.pos_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/b2da_dp.sv =====
// Datapath for the digit emitter: double-dabble shift register, bit counter,
// digit position counter and digit select. Depends on b2da_pkg.
`timescale 1ns / 1ps

module b2da_dp #(
  parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
  input  logic                                clk,
  input  b2da_pkg::b2da_cmd_t                 cmd,
  input  logic [b2da_pkg::NUM_BITS-1:0]       number,
  input  logic [b2da_pkg::COUNT_W-1:0]        digit_count,
  output b2da_pkg::b2da_stat_t                stat,
  output logic [b2da_pkg::CHAR_W-1:0]         digit_char
);
  import b2da_pkg::*;

  localparam int POS_W = $clog2(MAX_DIGITS);
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);

  logic [NUM_BITS-1:0]  bin;
  logic [3:0]           bcd      [NUM_POS];
  logic [3:0]           bcd_next [NUM_POS];
  logic [3:0]           adj      [NUM_POS];
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [POS_W-1:0]     pos;
  logic [COUNT_W-1:0]   sat_count;
  logic [COUNT_W-1:0]   top_pos;
  logic [3:0]           digit;

  assign sat_count = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;
  assign top_pos   = sat_count - COUNT_W'(1);

  // Add three to every digit of five or more, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      adj[i] = (bcd[i] >= DABBLE_LIMIT) ? (bcd[i] + DABBLE_ADJ) : bcd[i];
    end
    bcd_next[0] = {adj[0][2:0], bin[NUM_BITS-1]};
    for (int i = 1; i < NUM_POS; i++) begin
      bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= number;
      bit_cnt <= '0;
      pos     <= top_pos[POS_W-1:0];
      for (int i = 0; i < NUM_POS; i++) begin
        bcd[i] <= 4'd0;
      end
    end else if (cmd.shift) begin
      bin     <= {bin[NUM_BITS-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
      for (int i = 0; i < NUM_POS; i++) begin
        bcd[i] <= bcd_next[i];
      end
    end else if (cmd.advance) begin
      pos <= pos - POS_W'(1);
    end
  end

  // Positions past the tenth hold no digit of a 32-bit number: read as zero.
  always_comb begin
    digit = 4'd0;
    for (int i = 0; i < NUM_POS; i++) begin
      if (pos == POS_W'(i)) begin
        digit = bcd[i];
      end
    end
  end

  assign digit_char      = ASCII_ZERO + {2'b00, digit};
  assign stat.count_zero = (digit_count == '0);
  assign stat.conv_last  = (bit_cnt == BIT_CNT_W'(NUM_BITS - 1));
  assign stat.pos_zero   = (pos == '0);

endmodule

// ===== sv/binary_to_decimal_ascii_digits.sv =====
// Top level of the binary to decimal ASCII digit emitter.
// Depends on b2da_pkg, b2da_ctrl and b2da_dp.
//
//  channel  | dir | tdata (low bit up)                   | tuser | tlast
//  s_axis   | in  | [31:0] number, [36:32] digit_count   | -     | -
//  m_axis   | out | [5:0] digit_char, [7:6] zero         | -     | last_digit
//
// Flow: one item is accepted, converted by the bit-serial double-dabble loop
// (one input bit per cycle) and then emitted as N digits when it asks for
// N > 0 digits (after saturation to MAX_DIGITS, sixteen by default), with
// any sink stalls. A count of zero is accepted and dropped with no digits.
// Reset clears only the controller state; datapath registers load on accept.
// Stalls: hold a digit on m_axis until taken; take no new item until the final
// digit of the current one has been transferred.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_digits #(
  parameter int MAX_DIGITS = b2da_pkg::DEF_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] number, [36:32] digit_count, [39:37] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] digit_char, [7:6] zero
  output logic        m_axis_tlast    // last_digit: units digit of the run
);
  import b2da_pkg::*;

  b2da_cmd_t         cmd;
  b2da_stat_t        stat;
  logic [CHAR_W-1:0] digit_char;

  // Sequencer: owns both handshakes and steps the datapath.
  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Conversion registers and digit select; unpack the input fields here.
  b2da_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .number      (s_axis_tdata[NUM_BITS-1:0]),
    .digit_count (s_axis_tdata[NUM_BITS+COUNT_W-1:NUM_BITS]),
    .stat        (stat),
    .digit_char  (digit_char)
  );

  // Pad the ASCII code to a whole byte; mark the units digit as last.
  assign m_axis_tdata = {(8 - CHAR_W)'(0), digit_char};
  assign m_axis_tlast = stat.pos_zero;

endmodule

// ===== sv/b2da_chk.sv =====
// Port-level checker for the digit emitter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module b2da_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled digit steady.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled digit changed");

  // Never take input while digits are still being offered.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during digit output");

  // A zero count produces nothing and frees the input at once.
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[36:32] == 5'd0) |=>
      s_axis_tready && !m_axis_tvalid)
    else $error("zero count not dropped");

  // A non-zero count starts a conversion with neither side active.
  a_conv_start: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata[36:32] != 5'd0) |=>
      !s_axis_tready && !m_axis_tvalid)
    else $error("conversion did not start");

  // The final transfer of a run frees the input.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("input not freed after final digit");

endmodule

bind binary_to_decimal_ascii_digits b2da_chk u_b2da_chk (.*);
